FILE: src/jass_pkg.sv
// ----------------------------------------------------------------------------
// jass_pkg
// Shared types and constants for the JPEG APPn/COM segment stripper.
// ----------------------------------------------------------------------------
`default_nettype none

package jass_pkg;

  localparam logic [7:0] MarkerPrefix = 8'hFF;
  localparam logic [7:0] MarkerSoi    = 8'hD8;
  localparam logic [7:0] MarkerApp0   = 8'hE0;
  localparam logic [7:0] MarkerApp15  = 8'hEF;
  localparam logic [7:0] MarkerCom    = 8'hFE;
  localparam logic [7:0] MarkerSos    = 8'hDA;

  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  // One queue entry holds every output byte caused by one input byte.
  typedef struct packed {
    logic       malformed;
    logic [7:0] data1;
    logic [7:0] data0;
    logic       dual;
  } jass_entry_t;

endpackage : jass_pkg

`default_nettype wire

FILE: src/jass_front.sv
// ----------------------------------------------------------------------------
// jass_front
// Marker parser: accepts one byte per cycle while the queue is not full and pushes its kept bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module jass_front
  import jass_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic [7:0]  in_data_i,
  input  wire logic        in_last_i,
  input  wire logic        q_full_i,
  output logic             in_ready_o,
  output logic             push_o,
  output jass_entry_t      entry_o
);

  typedef enum logic [2:0] {
    PhFirst,
    PhSecond,
    PhIdle,
    PhHaveFf,
    PhLenHi,
    PhLenLo,
    PhPayload,
    PhPass
  } phase_e;

  phase_e      phase_q, phase_d;
  logic        skip_q, skip_d;
  logic        scan_q, scan_d;
  logic [7:0]  len_hi_q, len_hi_d;
  logic [15:0] rem_q, rem_d;
  logic        bad_q, bad_d;

  logic [1:0]  n;
  logic [7:0]  d0, d1;
  logic        held;
  logic        accept;
  logic        is_drop;
  logic [15:0] len;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign len        = {len_hi_q, in_data_i};
  assign is_drop    = ((in_data_i >= MarkerApp0) && (in_data_i <= MarkerApp15)) ||
                      (in_data_i == MarkerCom);

  always_comb begin
    phase_d  = phase_q;
    skip_d   = skip_q;
    scan_d   = scan_q;
    len_hi_d = len_hi_q;
    rem_d    = rem_q;
    bad_d    = bad_q;
    n        = 2'd0;
    d0       = in_data_i;
    d1       = in_data_i;
    held     = 1'b0;

    case (phase_q)
      PhFirst: begin
        if (in_data_i == MarkerPrefix) begin
          phase_d = PhSecond;
          held    = 1'b1;
        end else begin
          n       = 2'd1;
          phase_d = PhPass;
        end
      end
      PhSecond: begin
        n       = 2'd2;
        d0      = MarkerPrefix;
        phase_d = (in_data_i == MarkerSoi) ? PhIdle : PhPass;
      end
      PhIdle: begin
        if (in_data_i == MarkerPrefix) begin
          phase_d = PhHaveFf;
          held    = 1'b1;
        end else begin
          n = 2'd1;
        end
      end
      PhHaveFf: begin
        if (in_data_i == MarkerPrefix) begin
          n    = 2'd1;
          held = 1'b1;
        end else begin
          skip_d  = is_drop;
          scan_d  = (in_data_i == MarkerSos);
          phase_d = PhLenHi;
          if (!is_drop) begin
            n  = 2'd2;
            d0 = MarkerPrefix;
          end
        end
      end
      PhLenHi: begin
        len_hi_d = in_data_i;
        phase_d  = PhLenLo;
        if (!skip_q) n = 2'd1;
      end
      PhLenLo: begin
        if (len < 16'd2) begin
          bad_d = 1'b1;
          rem_d = 16'd0;
        end else begin
          rem_d = len - 16'd2;
        end
        if (!skip_q) n = 2'd1;
        if (rem_d == 16'd0) begin
          phase_d = scan_q ? PhPass : PhIdle;
          skip_d  = 1'b0;
        end else begin
          phase_d = PhPayload;
        end
      end
      PhPayload: begin
        if (!skip_q) n = 2'd1;
        rem_d = rem_q - 16'd1;
        if (rem_q == 16'd1) begin
          phase_d = scan_q ? PhPass : PhIdle;
          skip_d  = 1'b0;
        end
      end
      default: begin
        n       = 2'd1;
        phase_d = PhPass;
      end
    endcase

    // flush a held FF at end of stream
    if (in_last_i && held) begin
      if (n == 2'd0) begin
        n  = 2'd1;
        d0 = MarkerPrefix;
      end else begin
        n  = 2'd2;
        d1 = MarkerPrefix;
      end
    end
  end

  assign push_o          = accept && (n != 2'd0);
  assign entry_o.dual      = n[1];
  assign entry_o.data0     = d0;
  assign entry_o.data1     = d1;
  assign entry_o.malformed = bad_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhFirst;
      skip_q   <= 1'b0;
      scan_q   <= 1'b0;
      len_hi_q <= 8'd0;
      rem_q    <= 16'd0;
      bad_q    <= 1'b0;
    end else if (accept) begin
      if (in_last_i) begin
        phase_q  <= PhFirst;
        skip_q   <= 1'b0;
        scan_q   <= 1'b0;
        len_hi_q <= 8'd0;
        rem_q    <= 16'd0;
        bad_q    <= 1'b0;
      end else begin
        phase_q  <= phase_d;
        skip_q   <= skip_d;
        scan_q   <= scan_d;
        len_hi_q <= len_hi_d;
        rem_q    <= rem_d;
        bad_q    <= bad_d;
      end
    end
  end

endmodule : jass_front

`default_nettype wire

FILE: src/jass_fifo.sv
// ----------------------------------------------------------------------------
// jass_fifo
// Short queue of parsed entries between the parser and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module jass_fifo
  import jass_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire jass_entry_t  push_entry_i,
  input  wire logic         pop_i,
  output jass_entry_t       head_o,
  output logic              empty_o,
  output logic              full_o
);

  jass_entry_t            mem_q [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0]   cnt_q;
  logic                   do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == QueueCntW'(QueueDepth));
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + QueuePtrW'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + QueuePtrW'(1);
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + QueueCntW'(1);
        2'b01:   cnt_q <= cnt_q - QueueCntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule : jass_fifo

`default_nettype wire

FILE: src/jass_back.sv
// ----------------------------------------------------------------------------
// jass_back
// Output stage: splits queue entries into single bytes on a registered stream.
// ----------------------------------------------------------------------------
`default_nettype none

module jass_back
  import jass_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire jass_entry_t head_i,
  input  wire logic        empty_i,
  output logic             pop_o,
  output logic             out_valid_o,
  output logic [7:0]       out_data_o,
  output logic             out_last_o,
  output logic             out_mal_o,
  input  wire logic        out_ready_i
);

  logic       valid_q;
  logic [7:0] data_q;
  logic       last_q, mal_q;
  logic       pend_q;
  logic [7:0] pend_data_q;
  logic       pend_mal_q;
  logic       load;

  assign load  = !valid_q || out_ready_i;
  assign pop_o = load && !pend_q && !empty_i;

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;
  assign out_last_o  = last_q;
  assign out_mal_o   = mal_q;

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (pend_q) begin
        data_q <= pend_data_q;
        last_q <= 1'b1;
        mal_q  <= pend_mal_q;
      end else begin
        data_q <= head_i.data0;
        last_q <= !head_i.dual;
        mal_q  <= head_i.malformed;
      end
    end
    if (pop_o) begin
      pend_data_q <= head_i.data1;
      pend_mal_q  <= head_i.malformed;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pend_q  <= 1'b0;
    end else if (load) begin
      if (pend_q) begin
        valid_q <= 1'b1;
        pend_q  <= 1'b0;
      end else begin
        valid_q <= !empty_i;
        pend_q  <= !empty_i && head_i.dual;
      end
    end
  end

endmodule : jass_back

`default_nettype wire

FILE: src/jpeg_app_segment_stripper_unit.sv
// Path: a kept byte is written into the queue memory and then loaded into the output register.
// Throughput: one input byte per cycle while the queue is not full; one output byte per cycle
//   while the sink is ready, so the two outputs of one byte (marker pair, end-of-stream flush) go out in turn.
// The four-entry parse queue lets input continue while output is stalled.
// Reset (rst_ni low, async) empties queue and output, parser expects a new file.
// ----------------------------------------------------------------------------
// jpeg_app_segment_stripper_unit
// Byte-stream JPEG filter that drops APPn and COM marker segments.
// ----------------------------------------------------------------------------
`default_nettype none

module jpeg_app_segment_stripper_unit
  import jass_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  input  wire logic       s_axis_tlast_i,   // end_of_stream
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o,   // [7:0] out_byte
  output logic            m_axis_tlast_o,   // run_last
  output logic            m_axis_tuser_o    // [0] malformed
);

  jass_entry_t push_entry, head;
  logic        push, pop, empty, full;

  jass_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_data_i  (s_axis_tdata_i),
    .in_last_i  (s_axis_tlast_i),
    .q_full_i   (full),
    .in_ready_o (s_axis_tready_o),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  jass_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .head_o       (head),
    .empty_o      (empty),
    .full_o       (full)
  );

  jass_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_data_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o),
    .out_mal_o   (m_axis_tuser_o),
    .out_ready_i (m_axis_tready_i)
  );

endmodule : jpeg_app_segment_stripper_unit

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stream test of the JPEG APPn/COM segment stripper. Directed files cover the
// marker cases. A long sink stall fills the block. Random files, truncated
// files and noise follow. Every output transaction is compared with a
// byte-level parser model that runs alongside the stimulus.
// ----------------------------------------------------------------------------
module tb_top;
  import jass_pkg::*;

  localparam int HalfPeriod     = 6;
  localparam int ResetCycles    = 7;
  localparam int RandomItems    = 650;
  localparam int CalmItems      = 120;
  localparam int LongHoldCycles = 80;
  localparam int DrainCycles    = 20;
  localparam int CycleLimit     = 300000;

  typedef enum logic [3:0] {
    PhFirst, PhSecond, PhIdle, PhHaveFf, PhLenHi, PhLenLo, PhPayload, PhPass
  } parse_phase_e;

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       malformed;
  } kept_byte_t;

  logic       clk_i   = 1'b0;
  logic       rst_ni  = 1'b0;
  logic       s_valid = 1'b0;
  logic [7:0] s_data  = '0;
  logic       s_last  = 1'b0;
  logic       m_ready = 1'b0;
  logic       s_ready;
  logic       m_valid;
  logic [7:0] m_data;
  logic       m_last;
  logic       m_user;

  // parser model state
  parse_phase_e ph;
  logic         drop_seg;
  logic         in_scan;
  logic [7:0]   len_msb;
  logic [15:0]  seg_left;
  logic         bad_len;

  kept_byte_t  kept_q[$];
  logic [7:0]  jpeg_q[$];
  int          error_count  = 0;
  int          items_sent   = 0;
  int unsigned cycle_count  = 0;
  bit          src_idle_en  = 1'b0;
  bit          sink_idle_en = 1'b0;
  bit          hold_req     = 1'b0;

  jpeg_app_segment_stripper_unit i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),   // [7:0] in_byte
    .s_axis_tlast_i  (s_last),   // end_of_stream
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),   // [7:0] out_byte
    .m_axis_tlast_o  (m_last),   // run_last
    .m_axis_tuser_o  (m_user)    // [0] malformed
  );

  always #(HalfPeriod) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic void parser_reset();
    ph       = PhFirst;
    drop_seg = 1'b0;
    in_scan  = 1'b0;
    len_msb  = '0;
    seg_left = '0;
    bad_len  = 1'b0;
  endfunction

  function automatic void close_segment();
    ph       = in_scan ? PhPass : PhIdle;
    drop_seg = 1'b0;
  endfunction

  function automatic void add_expected(input logic [7:0] d);
    kept_byte_t e;
    e.data      = d;
    e.last      = 1'b0;
    e.malformed = bad_len;
    kept_q.insert(kept_q.size(), e);
  endfunction

  function automatic void add_file_byte(input logic [7:0] b);
    jpeg_q.insert(jpeg_q.size(), b);
  endfunction

  // Expected output bytes for one accepted input byte.
  function automatic void strip_predict(input logic [7:0] b, input logic eos);
    int          base;
    logic        held;
    logic [16:0] seg_len;
    base = kept_q.size();
    held = 1'b0;
    case (ph)
      PhFirst: begin
        if (b == MarkerPrefix) begin
          ph   = PhSecond;
          held = 1'b1;
        end else begin
          add_expected(b);
          ph = PhPass;
        end
      end
      PhSecond: begin
        add_expected(MarkerPrefix);
        add_expected(b);
        ph = (b == MarkerSoi) ? PhIdle : PhPass;
      end
      PhIdle: begin
        if (b == MarkerPrefix) begin
          ph   = PhHaveFf;
          held = 1'b1;
        end else begin
          add_expected(b);
        end
      end
      PhHaveFf: begin
        if (b == MarkerPrefix) begin
          add_expected(MarkerPrefix);
          held = 1'b1;
        end else begin
          drop_seg = (b >= MarkerApp0 && b <= MarkerApp15) || b == MarkerCom;
          in_scan  = (b == MarkerSos);
          if (!drop_seg) begin
            add_expected(MarkerPrefix);
            add_expected(b);
          end
          ph = PhLenHi;
        end
      end
      PhLenHi: begin
        len_msb = b;
        if (!drop_seg) add_expected(b);
        ph = PhLenLo;
      end
      PhLenLo: begin
        seg_len = {1'b0, len_msb, b};
        if (seg_len < 17'd2) begin
          seg_len = 17'd2;
          bad_len = 1'b1;
        end
        seg_left = 16'(seg_len - 17'd2);
        if (!drop_seg) add_expected(b);
        if (seg_left == 0) close_segment();
        else ph = PhPayload;
      end
      PhPayload: begin
        if (!drop_seg) add_expected(b);
        seg_left = seg_left - 16'd1;
        if (seg_left == 0) close_segment();
      end
      default: begin
        add_expected(b);
        ph = PhPass;
      end
    endcase
    if (eos && held) add_expected(MarkerPrefix);
    if (kept_q.size() > base) kept_q[kept_q.size() - 1].last = 1'b1;
    if (eos) parser_reset();
  endfunction

  // sink: random stall bursts, plus one long hold on request
  initial begin : sink_ready_gen
    int n;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_ready <= 1'b0;
        repeat (LongHoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (sink_idle_en && $urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 14);
        m_ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    kept_byte_t exp_b;
    if (rst_ni && m_valid && m_ready) begin
      if (kept_q.size() == 0) begin
        $display("%0t: unexpected transaction, got byte %h last %b malformed %b",
                 $time, m_data, m_last, m_user);
        error_count++;
      end else begin
        exp_b = kept_q.pop_front();
        if (m_data !== exp_b.data) begin
          $display("%0t: out_byte expected %h got %h", $time, exp_b.data, m_data);
          error_count++;
        end
        if (m_last !== exp_b.last) begin
          $display("%0t: run_last expected %b got %b", $time, exp_b.last, m_last);
          error_count++;
        end
        if (m_user !== exp_b.malformed) begin
          $display("%0t: malformed expected %b got %b", $time, exp_b.malformed, m_user);
          error_count++;
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eos);
    int gap;
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= b;
    s_last  <= eos;
    do @(posedge clk_i); while (!s_ready);
    strip_predict(b, eos);
    items_sent++;
  endtask

  task automatic send_file(input int cut);
    for (int i = 0; i < cut; i++) send_byte(jpeg_q[i], i == cut - 1);
  endtask

  task automatic wait_results();
    s_valid <= 1'b0;
    while (kept_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] rand_byte();
    return ($urandom_range(0, 3) == 0) ? MarkerPrefix : 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_marker();
    logic [7:0] m;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: m = MarkerApp0 + 8'($urandom_range(0, 15));
      4: m = MarkerCom;
      default: begin
        do m = 8'($urandom_range(0, 255));
        while ((m >= MarkerApp0 && m <= MarkerApp15) || m == MarkerCom ||
               m == MarkerSos || m == MarkerPrefix);
      end
    endcase
    return m;
  endfunction

  function automatic void put_segment(input logic [7:0] marker, input int payload,
                                      input bit short_len);
    int len;
    if ($urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 3)) add_file_byte(MarkerPrefix);
    end
    add_file_byte(MarkerPrefix);
    add_file_byte(marker);
    len = short_len ? $urandom_range(0, 1) : payload + 2;
    add_file_byte(len[15:8]);
    add_file_byte(len[7:0]);
    if (!short_len) repeat (payload) add_file_byte(rand_byte());
  endfunction

  function automatic void build_jpeg();
    jpeg_q.delete();
    add_file_byte(MarkerPrefix);
    add_file_byte(MarkerSoi);
    repeat ($urandom_range(0, 4)) begin
      put_segment(pick_marker(), $urandom_range(0, 6), $urandom_range(0, 15) == 0);
    end
    if ($urandom_range(0, 4) != 0) begin
      put_segment(MarkerSos, $urandom_range(0, 4), 1'b0);
      repeat ($urandom_range(1, 10)) add_file_byte(rand_byte());
    end else begin
      repeat ($urandom_range(0, 4)) add_file_byte(rand_byte());
    end
  endfunction

  function automatic void build_noise();
    jpeg_q.delete();
    if ($urandom_range(0, 1) == 0) begin
      add_file_byte(MarkerPrefix);
      add_file_byte(MarkerSoi);
    end
    repeat ($urandom_range(1, 8)) add_file_byte(rand_byte());
  endfunction

  task automatic test_segment_stripping();
    // APP0 dropped, short COM, fill FF, kept DQT, then scan data
    jpeg_q = '{8'hFF, 8'hD8, 8'hFF, 8'hE0, 8'h00, 8'h04, 8'hAA, 8'hBB,
               8'hFF, 8'hFE, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hDB, 8'h00,
               8'h03, 8'h55, 8'hFF, 8'hDA, 8'h00, 8'h02, 8'hFF, 8'hD9};
    send_file(jpeg_q.size());
  endtask

  task automatic test_stream_edges();
    jpeg_q = '{8'h12, 8'hFF};
    send_file(jpeg_q.size());
    jpeg_q = '{8'hFF};
    send_file(jpeg_q.size());
    jpeg_q = '{8'hFF, 8'hD8, 8'hFF};
    send_file(jpeg_q.size());
    jpeg_q = '{8'hFF, 8'h00};
    send_file(jpeg_q.size());
    // truncated inside an APP segment with maximum length
    jpeg_q = '{8'hFF, 8'hD8, 8'hFF, 8'hEF, 8'hFF, 8'hFF, 8'h01};
    send_file(jpeg_q.size());
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    jpeg_q.delete();
    add_file_byte(MarkerPrefix);
    add_file_byte(MarkerSoi);
    put_segment(8'hDB, 30, 1'b0);
    put_segment(MarkerSos, 2, 1'b0);
    repeat (8) add_file_byte(rand_byte());
    send_file(jpeg_q.size());
    wait_results();
  endtask

  task automatic test_random_files(input int n_items);
    int cut;
    int start;
    start = items_sent;
    while (items_sent - start < n_items) begin
      if ($urandom_range(0, 4) == 0) build_noise();
      else build_jpeg();
      cut = jpeg_q.size();
      if ($urandom_range(0, 7) == 0) cut = $urandom_range(1, cut);
      send_file(cut);
    end
  endtask

  initial begin
    parser_reset();
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    test_segment_stripping();
    test_stream_edges();
    test_backpressure();
    test_random_files(RandomItems - CalmItems - items_sent);
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    test_random_files(CalmItems);
    wait_results();
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
